// File: hdl/lzwd_pkg.sv
// Shared types and constants for the LZSS window decoder.
// Used by lzwd_ctrl, lzwd_datapath and lzss_window_decoder; no dependencies.
package lzwd_pkg;

  // History window geometry (a power of two from 256 to 4096).
  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = WIN_AW + 1;

  // Token format constants.
  localparam int OFS_W     = 12;
  localparam int CMP_W     = 13;
  localparam int LEN_W     = 5;
  localparam int MIN_MATCH = 3;
  localparam int GROUP_LEN = 8;
  localparam int TOK_W     = 4;
  localparam int COUNT_W   = 16;

  // Position inside the compressed token stream.
  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH2
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lit_emit;     // emit the input byte as a literal
    logic mark_emit;    // emit a bare end marker
    logic trunc;        // marker comes from a cut-off match
    logic save_first;   // hold the first byte of a match
    logic match_start;  // decode offset and length from the second byte
    logic rd_issue;     // read the next match byte from the window
    logic copy_emit;    // emit the byte read from the window
    logic blk_end;      // this result closes the block
    logic run_last;     // this result is the last one for the item
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic copy_last;    // the pending match byte is its final one
  } dp_stat_t;

endpackage

// File: hdl/lzwd_datapath.sv
// Datapath of the LZSS window decoder: history window, counters, match
// copy unit and the output register. Depends on lzwd_pkg.
module lzwd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lzwd_pkg::dp_cmd_t  cmd,
  output lzwd_pkg::dp_stat_t stat,
  input  logic [7:0]         comp_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         data_byte,
  output logic               has_byte,
  output logic               last_of_run,
  output logic               block_end,
  output logic [15:0]        bytes_so_far,
  output logic               bad_reference,
  output logic               truncated
);
  import lzwd_pkg::*;

  logic [7:0]         window [WINDOW_DEPTH];
  logic [7:0]         rd_data;
  logic [WIN_AW-1:0]  wptr;
  logic [WIN_AW-1:0]  src;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_inc;
  logic [7:0]         first_byte;
  logic [LEN_W-1:0]   remain;
  logic               bad;
  logic [OFS_W-1:0]   offset;
  logic               emit;
  logic [7:0]         emit_byte;

  // Offset of a match, the byte that an emission writes, and the next count and fill.
  always_comb begin
    offset    = {first_byte[7:4], comp_byte};
    emit      = cmd.lit_emit | cmd.copy_emit;
    emit_byte = cmd.lit_emit ? comp_byte : (bad ? 8'h00 : rd_data);
    count_inc = count + COUNT_W'(1);
    fill_inc  = (fill == FILL_W'(WINDOW_DEPTH)) ? fill : fill + FILL_W'(1);
  end

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.copy_last = (remain == LEN_W'(1));

  // History window: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (emit) begin
      window[wptr] <= emit_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= window[src];
    end
  end

  // Match decode and copy bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.save_first) begin
      first_byte <= comp_byte;
    end
    if (cmd.match_start) begin
      src    <= wptr - offset[WIN_AW-1:0];
      remain <= LEN_W'(first_byte[3:0]) + LEN_W'(MIN_MATCH);
      bad    <= (offset == '0) || (CMP_W'(offset) > CMP_W'(fill));
    end else begin
      if (cmd.rd_issue) begin
        src <= src + WIN_AW'(1);
      end
      if (cmd.copy_emit) begin
        remain <= remain - LEN_W'(1);
      end
    end
  end

  // Write pointer, block byte count and window fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      count <= '0;
      fill  <= '0;
    end else begin
      if (emit) begin
        wptr <= wptr + WIN_AW'(1);
      end
      if ((emit || cmd.mark_emit) && cmd.blk_end) begin
        count <= '0;
        fill  <= '0;
      end else if (emit) begin
        count <= count_inc;
        fill  <= fill_inc;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || cmd.mark_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      data_byte     <= emit_byte;
      has_byte      <= 1'b1;
      last_of_run   <= cmd.run_last;
      block_end     <= cmd.blk_end;
      bytes_so_far  <= count_inc;
      bad_reference <= cmd.copy_emit & bad;
      truncated     <= 1'b0;
    end else if (cmd.mark_emit) begin
      data_byte     <= 8'h00;
      has_byte      <= 1'b0;
      last_of_run   <= 1'b1;
      block_end     <= 1'b1;
      bytes_so_far  <= count;
      bad_reference <= 1'b0;
      truncated     <= cmd.trunc;
    end
  end

endmodule

// File: hdl/lzwd_ctrl.sv
// Controller of the LZSS window decoder: token parser and match sequencer.
// Drives datapath commands; depends on lzwd_pkg.
module lzwd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         comp_byte,
  input  logic               stream_end,
  output lzwd_pkg::dp_cmd_t  cmd,
  input  lzwd_pkg::dp_stat_t stat
);
  import lzwd_pkg::*;

  ctl_state_t       state;
  ctl_state_t       state_next;
  phase_t           phase;
  phase_t           phase_next;
  logic [7:0]       flag_shift;
  logic [7:0]       flag_shift_next;
  logic [TOK_W-1:0] tokens_left;
  logic [TOK_W-1:0] tokens_left_next;
  logic             end_pend;
  logic             end_pend_next;
  logic             accept;
  logic             advance;
  logic             clear_block;
  logic [TOK_W-1:0] tokens_dec;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_FLAG;
      flag_shift  <= '0;
      tokens_left <= '0;
      end_pend    <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      flag_shift  <= flag_shift_next;
      tokens_left <= tokens_left_next;
      end_pend    <= end_pend_next;
    end
  end

  // Next state, token bookkeeping and datapath commands.
  always_comb begin
    in_stall         = !((state == ST_IDLE) && stat.out_free);
    accept           = in_valid && !in_stall;
    state_next       = state;
    phase_next       = phase;
    flag_shift_next  = flag_shift;
    tokens_left_next = tokens_left;
    end_pend_next    = end_pend;
    cmd              = '0;
    advance          = 1'b0;
    clear_block      = 1'b0;
    tokens_dec       = (tokens_left == '0) ? tokens_left : tokens_left - TOK_W'(1);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            PH_TOKEN: begin
              if (flag_shift[7]) begin
                if (stream_end) begin
                  cmd.mark_emit = 1'b1;
                  cmd.trunc     = 1'b1;
                  cmd.blk_end   = 1'b1;
                  clear_block   = 1'b1;
                end else begin
                  cmd.save_first = 1'b1;
                  phase_next     = PH_MATCH2;
                end
              end else begin
                cmd.lit_emit = 1'b1;
                cmd.run_last = 1'b1;
                cmd.blk_end  = stream_end;
                advance      = 1'b1;
                clear_block  = stream_end;
              end
            end
            PH_MATCH2: begin
              cmd.match_start = 1'b1;
              end_pend_next   = stream_end;
              state_next      = ST_READ;
            end
            default: begin
              flag_shift_next  = comp_byte;
              tokens_left_next = TOK_W'(GROUP_LEN);
              phase_next       = PH_TOKEN;
              if (stream_end) begin
                cmd.mark_emit = 1'b1;
                cmd.blk_end   = 1'b1;
                clear_block   = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.copy_emit = 1'b1;
          cmd.run_last  = stat.copy_last;
          cmd.blk_end   = stat.copy_last && end_pend;
          if (stat.copy_last) begin
            advance     = 1'b1;
            clear_block = end_pend;
            state_next  = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Move to the next token of the flag group.
    if (advance) begin
      flag_shift_next  = {flag_shift[6:0], 1'b0};
      tokens_left_next = tokens_dec;
      phase_next       = (tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
    end

    // A block end returns the parser to its start.
    if (clear_block) begin
      phase_next       = PH_FLAG;
      flag_shift_next  = '0;
      tokens_left_next = '0;
    end
  end

endmodule

// File: hdl/lzss_window_decoder.sv
// LZSS window decoder, 12-bit offset and 4-bit length, 4096-byte history.
// Flag bytes, literals and first match bytes are each taken in the idle state; the second
// match byte starts a copy of 3 to 18 bytes, each read through the single window read
// port and then written and emitted, and holds the input until the copy ends. A
// literal's result is registered in the cycle after it is taken. Each copied byte
// passes the read and emit states; a stalled output holds it in emit. Synchronous reset
// clears the parser, counters and output valid; window data is undefined until written.
module lzss_window_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  comp_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        has_byte,
  output logic        last_of_run,
  output logic        block_end,
  output logic [15:0] bytes_so_far,
  output logic        bad_reference,
  output logic        truncated
);
  import lzwd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Token parser and match sequencer.
  lzwd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .comp_byte  (comp_byte),
    .stream_end (stream_end),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Window, counters and output register.
  lzwd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .comp_byte     (comp_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .has_byte      (has_byte),
    .last_of_run   (last_of_run),
    .block_end     (block_end),
    .bytes_so_far  (bytes_so_far),
    .bad_reference (bad_reference),
    .truncated     (truncated)
  );

endmodule

// File: sim/tb_lzss_window_decoder.sv
// Self-checking testbench for lzss_window_decoder: directed token table, then random blocks.
// A local model predicts all but hand-written results. Depends on lzwd_pkg and decoder RTL.
module tb_lzss_window_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwd_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD    = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 150;
  localparam int CLOSING_ITEMS = 40;
  localparam int TAIL_CYCLES  = 20;

  // One decoded result; data_ok is cleared where the decoder's byte is undefined.
  typedef struct packed {
    logic [7:0]  data;
    logic        has;
    logic        last;
    logic        bend;
    logic [15:0] cnt;
    logic        bad;
    logic        trunc;
    logic        data_ok;
  } dec_out_t;

  // One line of the directed table.
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       fixed;
    dec_out_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  comp_byte;
  logic        stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_of_run;
  logic        block_end;
  logic [15:0] bytes_so_far;
  logic        bad_reference;
  logic        truncated;

  lzss_window_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .comp_byte    (comp_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .last_of_run  (last_of_run),
    .block_end    (block_end),
    .bytes_so_far (bytes_so_far),
    .bad_reference(bad_reference),
    .truncated    (truncated)
  );

  always #5 clk = ~clk;

  // Decoder model state.
  phase_t             dec_phase   = PH_FLAG;
  logic [7:0]         dec_flags   = '0;
  logic [3:0]         dec_tokens  = '0;
  logic [7:0]         dec_first   = '0;
  logic [WIN_AW-1:0]  win_ptr     = '0;
  logic [15:0]        blk_count   = '0;
  logic [FILL_W-1:0]  win_fill    = '0;
  logic [7:0]         win_data  [WINDOW_DEPTH];
  bit                 win_known [WINDOW_DEPTH];

  dec_out_t  item_results[$];
  dec_out_t  awaited_results[$];
  plan_row_t plan[$];

  // Stimulus and pacing control.
  logic [7:0] match_lo      = '0;
  bit         noisy         = 1'b0;
  bit         zero_push     = 1'b0;
  bit         steady        = 1'b0;
  bit         long_hold_done = 1'b0;
  int         gap_mode      = 2;
  int         stall_mode    = 2;
  int         results_taken = 0;
  int         mismatch_count = 0;
  int         dead_cycles   = 0;

  function automatic bit one_in(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // Emit one output byte and write it into the history window.
  function automatic void store_byte(input logic [7:0] d, input bit known, input logic bad);
    dec_out_t r;
    win_data[win_ptr]  = d;
    win_known[win_ptr] = known;
    win_ptr   = win_ptr + WIN_AW'(1);
    blk_count = blk_count + 16'(1);
    if (win_fill < FILL_W'(WINDOW_DEPTH)) win_fill = win_fill + FILL_W'(1);
    r = '0;
    r.data    = d;
    r.has     = 1'b1;
    r.cnt     = blk_count;
    r.bad     = bad;
    r.data_ok = known;
    item_results.push_back(r);
  endfunction

  function automatic void next_token();
    dec_flags = dec_flags << 1;
    if (dec_tokens != 0) dec_tokens = dec_tokens - 4'(1);
    dec_phase = (dec_tokens == 0) ? PH_FLAG : PH_TOKEN;
  endfunction

  // Work out the results of one compressed byte into item_results.
  function automatic void decode_item(input logic [7:0] b, input logic e);
    logic             cut;
    logic [11:0]      ofs;
    logic [WIN_AW-1:0] src;
    int               len;
    logic             bad;
    dec_out_t         r;
    item_results.delete();
    cut = 1'b0;
    case (dec_phase)
      PH_TOKEN: begin
        if (dec_flags[7]) begin
          if (e) begin
            cut = 1'b1;
          end else begin
            dec_first = b;
            dec_phase = PH_MATCH2;
          end
        end else begin
          store_byte(b, 1'b1, 1'b0);
          next_token();
        end
      end
      PH_MATCH2: begin
        ofs = {dec_first[7:4], b};
        len = int'(dec_first[3:0]) + MIN_MATCH;
        bad = (ofs == '0) || (FILL_W'(ofs) > win_fill);
        for (int i = 0; i < len; i++) begin
          if (bad) begin
            store_byte(8'h00, 1'b0, 1'b1);
          end else begin
            src = win_ptr - ofs;
            store_byte(win_data[src], win_known[src], 1'b0);
          end
        end
        next_token();
      end
      default: begin
        dec_flags  = b;
        dec_tokens = 4'(GROUP_LEN);
        dec_phase  = PH_TOKEN;
      end
    endcase
    // A block end closes the item with a flagged result and clears the block state.
    if (e) begin
      if (item_results.size() == 0) begin
        r = '0;
        r.cnt     = blk_count;
        r.trunc   = cut;
        r.data_ok = 1'b1;
        item_results.push_back(r);
      end
      r = item_results.pop_back();
      r.bend = 1'b1;
      item_results.push_back(r);
      dec_phase  = PH_FLAG;
      dec_flags  = '0;
      dec_tokens = '0;
      blk_count  = '0;
      win_fill   = '0;
    end
    if (item_results.size() != 0) begin
      r = item_results.pop_back();
      r.last = 1'b1;
      item_results.push_back(r);
    end
  endfunction

  function automatic void queue_expected();
    foreach (item_results[i]) awaited_results.push_back(item_results[i]);
  endfunction

  function automatic void plan_row(input logic [7:0] b, input logic e);
    plan_row_t p;
    p = '0;
    p.b = b;
    p.e = e;
    plan.push_back(p);
  endfunction

  // Row whose single result is written out by hand.
  function automatic void plan_fixed(input logic [7:0] b, input logic e, input logic [7:0] d,
                                     input logic has, input logic bend, input logic [15:0] cnt,
                                     input logic trunc);
    plan_row_t p;
    p = '0;
    p.b            = b;
    p.e            = e;
    p.fixed        = 1'b1;
    p.want.data    = d;
    p.want.has     = has;
    p.want.last    = 1'b1;
    p.want.bend    = bend;
    p.want.cnt     = cnt;
    p.want.trunc   = trunc;
    p.want.data_ok = 1'b1;
    plan.push_back(p);
  endfunction

  // Choose a match offset: mostly inside the bytes of this block, sometimes offset
  // zero or one reaching before the block start.
  function automatic int pick_offset();
    int near_max;
    int kind;
    near_max = (win_fill > FILL_W'(4095)) ? 4095 : int'(win_fill);
    kind     = int'($urandom_range(0, 9));
    if (kind < (zero_push ? 4 : 1)) return 0;
    if ((kind == 1 || near_max == 0) && near_max < 4095) begin
      if (one_in(2)) return near_max + 1;
      return int'($urandom_range(near_max + 1, 4095));
    end
    if (kind == 2) return near_max;
    return int'($urandom_range(1, (near_max < 24) ? near_max : 24));
  endfunction

  // Next compressed byte, shaped by where the decoder stands in its token stream.
  function automatic void next_stream_byte(output logic [7:0] b, output logic e);
    int ofs;
    int len_code;
    e = 1'b0;
    case (dec_phase)
      PH_TOKEN: begin
        if (!dec_flags[7]) begin
          b = 8'($urandom_range(0, 255));
          e = one_in(noisy ? 5 : 30);
        end else begin
          ofs = pick_offset();
          case ($urandom_range(0, 7))
            0: len_code = 15;
            1: len_code = 0;
            default: len_code = int'($urandom_range(0, 4));
          endcase
          e = noisy && one_in(4);
          b = {ofs[11:8], len_code[3:0]};
          match_lo = ofs[7:0];
        end
      end
      PH_MATCH2: begin
        b = match_lo;
        e = one_in(noisy ? 5 : 30);
      end
      default: begin
        case ($urandom_range(0, 9))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        e = one_in(noisy ? 5 : 60);
      end
    endcase
    if (e) noisy = one_in(4);
  endfunction

  // Present one item and hold it until the decoder takes it, then predict its results.
  task automatic send_item(input logic [7:0] b, input logic e);
    if (!steady && one_in(16)) gap_mode = int'($urandom_range(0, 4));
    if (!steady && gap_mode != 0 && $urandom_range(0, 7) < gap_mode) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    comp_byte  <= b;
    stream_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_item(b, e);
  endtask

  task automatic send_generated(input bit close_block);
    logic [7:0] b;
    logic       e;
    next_stream_byte(b, e);
    if (close_block) e = 1'b1;
    send_item(b, e);
    queue_expected();
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Main sequence: reset, directed table, random blocks, closing burst.
  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    comp_byte  = '0;
    stream_end = 1'b0;

    // Literals at both extremes, an overlapping copy and a longest match reaching back to the
    // block start; the block then ends in the middle of a flag group.
    plan_row  (8'h18, 1'b0);
    plan_fixed(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 16'd1, 1'b0);
    plan_fixed(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, 16'd2, 1'b0);
    plan_fixed(8'hA5, 1'b0, 8'hA5, 1'b1, 1'b0, 16'd3, 1'b0);
    plan_row  (8'h00, 1'b0);
    plan_row  (8'h01, 1'b0);
    plan_row  (8'h0F, 1'b0);
    plan_row  (8'h06, 1'b0);
    plan_fixed(8'h3C, 1'b0, 8'h3C, 1'b1, 1'b0, 16'd25, 1'b0);
    plan_fixed(8'hC3, 1'b1, 8'hC3, 1'b1, 1'b1, 16'd26, 1'b0);
    // Match reaching before the start of the block, then a literal that ends it.
    plan_row  (8'h80, 1'b0);
    plan_row  (8'h00, 1'b0);
    plan_row  (8'h14, 1'b0);
    plan_fixed(8'h7E, 1'b1, 8'h7E, 1'b1, 1'b1, 16'd4, 1'b0);
    // Block end right on a flag byte gives a bare marker.
    plan_fixed(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0, 1'b0);
    // Block end on the first byte of a match drops it.
    plan_row  (8'h40, 1'b0);
    plan_fixed(8'h01, 1'b0, 8'h01, 1'b1, 1'b0, 16'd1, 1'b0);
    plan_fixed(8'h2F, 1'b1, 8'h00, 1'b0, 1'b1, 16'd1, 1'b1);
    // Longest match whose second byte ends the block.
    plan_row  (8'h40, 1'b0);
    plan_fixed(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, 16'd1, 1'b0);
    plan_row  (8'h0F, 1'b0);
    plan_row  (8'h01, 1'b1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_item(plan[i].b, plan[i].e);
      if (plan[i].fixed) awaited_results.push_back(plan[i].want);
      else queue_expected();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) send_generated(1'b0);

    // Closing burst with no idling on either side.
    steady    = 1'b1;
    zero_push = 1'b1;
    for (int n = 0; n < CLOSING_ITEMS; n++) send_generated(n == CLOSING_ITEMS - 1);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Output stall pacing: random bursts, plus one long hold that backs the decoder up.
  initial begin : sink_pacing
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!steady && one_in(64)) stall_mode = int'($urandom_range(0, 4));
      if (!steady && !long_hold_done && results_taken >= 120) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!steady && stall_mode != 0 && $urandom_range(0, 15) < stall_mode) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    dec_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_taken++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: data_byte %0h has_byte %0b block_end %0b",
               data_byte, has_byte, block_end);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (want.data_ok) check_field("data_byte", 16'(want.data), 16'(data_byte));
        check_field("has_byte", 16'(want.has), 16'(has_byte));
        check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        check_field("block_end", 16'(want.bend), 16'(block_end));
        check_field("bytes_so_far", want.cnt, bytes_so_far);
        check_field("bad_reference", 16'(want.bad), 16'(bad_reference));
        check_field("truncated", 16'(want.trunc), 16'(truncated));
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
    end
    if (dead_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
